// ===== hdl/lsw_pkg.sv =====
// Shared types and constants for the learning switch with server pick.
// No dependencies; imported by learning_switch_random_server_pick.
package lsw_pkg;

    localparam int PORT_W  = 16;
    localparam int MAC_W   = 48;
    localparam int IP_W    = 32;
    localparam int LFSR_W  = 32;
    localparam int CNT_W   = 8;
    localparam int ENTRY_W = MAC_W + PORT_W;
    localparam int PADDR_W = 3;

    localparam logic [MAC_W-1:0]  MAC_BCAST = '1;
    localparam logic [LFSR_W-1:0] LFSR_TAPS = 32'h8020_0003;

    // Register index taken from paddr[2].
    localparam logic REG_SERVER_COUNT = 1'b0;
    localparam logic REG_RANDOM_SEED  = 1'b1;

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_SEARCH = 6'b000010,
        ST_LEARN  = 6'b000100,
        ST_DRAW   = 6'b001000,
        ST_SCALE  = 6'b010000,
        ST_RESULT = 6'b100000
    } lsw_state_t;

    // One Galois step of the x^32+x^22+x^2+x+1 generator.
    function automatic logic [LFSR_W-1:0] lfsr_step(input logic [LFSR_W-1:0] v);
        logic [LFSR_W-1:0] s;
        s = v >> 1;
        if (v[0]) begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

// ===== hdl/learning_switch_random_server_pick.sv =====
// MAC learning switch with random server pick for ARP probes: top level.
// Depends on lsw_pkg (widths, state codes, LFSR step).
//
// Usage
// - Input channel s_*: one packet-in event per beat (ingress port, source and
//   destination MAC, source IPv4). s_ready is high only while the sequencer is
//   idle; one event is worked on at a time.
// - Result channel m_*: one result beat per event (egress port, flood,
//   server_picked, newly_learned, table_full), held in an output register.
// - Configuration: APB-style port, server_count at 0x0, random_seed at 0x4.
//   Writing the seed also reloads the LFSR (zero loads 1). Write only when idle.
// Per event, one comparator walks the table one entry a cycle through the
// memory's registered read port; a learn step and a result step follow, and
// an ARP probe adds 32 single-step LFSR shifts and one multiply before the
// result.
// Reset: the table is emptied at once through its fill count (entries are
// never removed, so index < count means valid); no clearing pass is needed.
// Stall: a pending result waits in the output register; the next event may be
// taken meanwhile and its result waits in the sequencer until the register frees.
module learning_switch_random_server_pick
    import lsw_pkg::*;
#(
    parameter int TABLE_ENTRIES   = 64,
    parameter int DEFAULT_SERVERS = 4,
    parameter int FLOOD_CODE      = 65531
) (
    input  logic                aclk,
    input  logic                aresetn,

    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,

    input  logic                s_valid,
    output logic                s_ready,
    input  logic [PORT_W-1:0]   s_ingress_port,
    input  logic [MAC_W-1:0]    s_source_mac,
    input  logic [MAC_W-1:0]    s_dest_mac,
    input  logic [IP_W-1:0]     s_source_ip,

    output logic                m_valid,
    input  logic                m_ready,
    output logic [PORT_W-1:0]   m_egress_port,
    output logic                m_flood,
    output logic                m_server_picked,
    output logic                m_newly_learned,
    output logic                m_table_full
);

    localparam int AW   = $clog2(TABLE_ENTRIES);
    localparam int UW   = $clog2(TABLE_ENTRIES + 1);
    localparam int PRODW = LFSR_W + CNT_W + 1;
    localparam logic [UW-1:0]     ENTRIES_MAX = UW'(TABLE_ENTRIES);
    localparam logic [CNT_W-1:0]  DEF_COUNT   = CNT_W'(DEFAULT_SERVERS);
    localparam logic [PORT_W-1:0] FLOOD_PORT  = PORT_W'(FLOOD_CODE);

    // ---------------------------------------------------------------
    // Configuration registers
    // ---------------------------------------------------------------
    logic [CNT_W-1:0]  server_count_reg;
    logic [LFSR_W-1:0] random_seed_reg;
    logic              cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == REG_RANDOM_SEED) ? random_seed_reg
                                                  : {24'd0, server_count_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            server_count_reg <= '0;
            random_seed_reg  <= 32'd1;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_SERVER_COUNT: server_count_reg <= pwdata[CNT_W-1:0];
                REG_RANDOM_SEED:  random_seed_reg  <= pwdata;
                default:          server_count_reg <= server_count_reg;
            endcase
        end
    end

    // ---------------------------------------------------------------
    // Sequencer state and event registers
    // ---------------------------------------------------------------
    lsw_state_t        state_reg, state_next;
    logic [UW-1:0]     used_reg, used_next;
    logic [UW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [4:0]        step_reg, step_next;
    logic [LFSR_W-1:0] lfsr_reg, lfsr_next;
    logic [PRODW-1:0]  prod_reg, prod_next;

    logic [PORT_W-1:0] port_in_reg, port_in_next;
    logic [MAC_W-1:0]  src_reg, src_next;
    logic [MAC_W-1:0]  dst_reg, dst_next;
    logic              bcast_reg, bcast_next;
    logic              probe_reg, probe_next;

    logic              src_hit_reg, src_hit_next;
    logic              dst_hit_reg, dst_hit_next;
    logic [PORT_W-1:0] dst_port_reg, dst_port_next;
    logic              learned_reg, learned_next;
    logic              full_reg, full_next;

    logic              m_valid_reg, m_valid_next;
    logic [PORT_W-1:0] m_egress_reg, m_egress_next;
    logic              m_flood_reg, m_flood_next;
    logic              m_picked_reg, m_picked_next;
    logic              m_learned_reg, m_learned_next;
    logic              m_full_reg, m_full_next;

    // Table memory: {mac, port} per entry, one write and one registered read.
    logic [ENTRY_W-1:0] tbl_mem [TABLE_ENTRIES];
    logic [ENTRY_W-1:0] rd_data_reg;
    logic               wr_en;
    logic [MAC_W-1:0]   rd_mac;
    logic [PORT_W-1:0]  rd_port;
    logic [CNT_W:0]     draw_range;
    logic               out_free;

    assign rd_mac     = rd_data_reg[ENTRY_W-1:PORT_W];
    assign rd_port    = rd_data_reg[PORT_W-1:0];
    assign draw_range = (server_count_reg != '0) ? {1'b0, server_count_reg} + 1'b1
                                                 : {1'b0, DEF_COUNT} + 1'b1;
    assign out_free   = !m_valid_reg || m_ready;

    assign s_ready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            tbl_mem[used_reg[AW-1:0]] <= {src_reg, port_in_reg};
        end
        rd_data_reg <= tbl_mem[idx_reg[AW-1:0]];
    end

    always_comb begin
        state_next     = state_reg;
        used_next      = used_reg;
        idx_next       = idx_reg;
        pend_next      = pend_reg;
        step_next      = step_reg;
        lfsr_next      = lfsr_reg;
        prod_next      = prod_reg;
        port_in_next   = port_in_reg;
        src_next       = src_reg;
        dst_next       = dst_reg;
        bcast_next     = bcast_reg;
        probe_next     = probe_reg;
        src_hit_next   = src_hit_reg;
        dst_hit_next   = dst_hit_reg;
        dst_port_next  = dst_port_reg;
        learned_next   = learned_reg;
        full_next      = full_reg;
        wr_en          = 1'b0;
        m_valid_next   = m_valid_reg && !m_ready;
        m_egress_next  = m_egress_reg;
        m_flood_next   = m_flood_reg;
        m_picked_next  = m_picked_reg;
        m_learned_next = m_learned_reg;
        m_full_next    = m_full_reg;

        // Seed write reloads the generator; zero would lock it.
        if (cfg_wr && paddr[2] == REG_RANDOM_SEED) begin
            lfsr_next = (pwdata != '0) ? pwdata : 32'd1;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    port_in_next  = s_ingress_port;
                    src_next      = s_source_mac;
                    dst_next      = s_dest_mac;
                    bcast_next    = (s_dest_mac == MAC_BCAST);
                    probe_next    = (s_dest_mac == MAC_BCAST) && (s_source_ip == '0);
                    idx_next      = '0;
                    pend_next     = 1'b0;
                    src_hit_next  = 1'b0;
                    dst_hit_next  = 1'b0;
                    learned_next  = 1'b0;
                    full_next     = 1'b0;
                    state_next    = ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                // Issue one read a cycle; compare the data of the previous read.
                if (idx_reg != used_reg) begin
                    idx_next  = idx_reg + 1'b1;
                    pend_next = 1'b1;
                end else begin
                    pend_next = 1'b0;
                end
                if (pend_reg) begin
                    if (rd_mac == src_reg) begin
                        src_hit_next = 1'b1;
                    end
                    if (!bcast_reg && !dst_hit_reg && rd_mac == dst_reg) begin
                        dst_hit_next  = 1'b1;
                        dst_port_next = rd_port;
                    end
                end else if (idx_reg == used_reg) begin
                    state_next = ST_LEARN;
                end
            end
            ST_LEARN: begin
                if (!src_hit_reg) begin
                    if (used_reg != ENTRIES_MAX) begin
                        wr_en        = 1'b1;
                        used_next    = used_reg + 1'b1;
                        learned_next = 1'b1;
                        // A source learned now is visible to its own lookup.
                        if (!bcast_reg && !dst_hit_reg && dst_reg == src_reg) begin
                            dst_hit_next  = 1'b1;
                            dst_port_next = port_in_reg;
                        end
                    end else begin
                        full_next = 1'b1;
                    end
                end
                step_next  = '0;
                state_next = probe_reg ? ST_DRAW : ST_RESULT;
            end
            ST_DRAW: begin
                lfsr_next = lfsr_step(lfsr_reg);
                step_next = step_reg + 1'b1;
                if (step_reg == '1) begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE: begin
                prod_next  = {{(CNT_W+1){1'b0}}, lfsr_reg} * {{LFSR_W{1'b0}}, draw_range};
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                // Hold here until the output register frees.
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_picked_next  = probe_reg;
                    m_learned_next = learned_reg;
                    m_full_next    = full_reg;
                    if (probe_reg) begin
                        m_egress_next = PORT_W'(prod_reg[PRODW-1:LFSR_W]);
                        m_flood_next  = 1'b0;
                    end else if (dst_hit_reg) begin
                        m_egress_next = dst_port_reg;
                        m_flood_next  = 1'b0;
                    end else begin
                        m_egress_next = FLOOD_PORT;
                        m_flood_next  = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            used_reg    <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            step_reg    <= '0;
            lfsr_reg    <= 32'd1;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            idx_reg     <= idx_next;
            pend_reg    <= pend_next;
            step_reg    <= step_next;
            lfsr_reg    <= lfsr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg      <= prod_next;
        port_in_reg   <= port_in_next;
        src_reg       <= src_next;
        dst_reg       <= dst_next;
        bcast_reg     <= bcast_next;
        probe_reg     <= probe_next;
        src_hit_reg   <= src_hit_next;
        dst_hit_reg   <= dst_hit_next;
        dst_port_reg  <= dst_port_next;
        learned_reg   <= learned_next;
        full_reg      <= full_next;
        m_egress_reg  <= m_egress_next;
        m_flood_reg   <= m_flood_next;
        m_picked_reg  <= m_picked_next;
        m_learned_reg <= m_learned_next;
        m_full_reg    <= m_full_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_egress_port   = m_egress_reg;
    assign m_flood         = m_flood_reg;
    assign m_server_picked = m_picked_reg;
    assign m_newly_learned = m_learned_reg;
    assign m_table_full    = m_full_reg;

endmodule
